### rtl/assert_macros.svh
// assertion helpers shared by dtvr_dp and dtvr_ctrl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only while out of reset
`define AST_ON_CLK(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked at every edge, reset included
`define AST_NO_RST(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/dtvr_pkg.sv
// ---------------------------------------------------------------------------
// dtvr_pkg
// shared types and constants of the definite time voltage regulator
// ---------------------------------------------------------------------------
package dtvr_pkg;

  localparam int CH_NUM    = 3;
  localparam int CH_W      = 2;
  localparam int CFG_IDX_W = 2;
  localparam int REG_W     = 16;
  localparam int FIELD_W   = 16;

  localparam logic [CH_W-1:0]  CH_LAST         = 2'd2;
  localparam logic [REG_W-1:0] UPPER_RST       = 16'd32768;
  localparam logic [REG_W-1:0] LOWER_RST       = 16'd0;
  localparam logic [REG_W-1:0] DELAY_RST       = 16'd500;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_UPPER = 2'd0,
    REG_LOWER = 2'd1,
    REG_DELAY = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic            load;
    logic            square;
    logic            accum;
    logic            pos_step;
    logic            root_start;
    logic            rms_store;
    logic            eval;
    logic            tick;
    logic            publish;
    logic [CH_W-1:0] ch;
  } cmd_t;

  typedef struct packed {
    logic op_tick;
    logic win_last;
    logic root_done;
  } st_t;

endpackage

### rtl/dtvr_root.sv
// ---------------------------------------------------------------------------
// dtvr_root
// digit-by-digit square root of a window sum scaled by the window length
// ---------------------------------------------------------------------------
module dtvr_root #(
  parameter int SAMPLES     = 16,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                                                  clk,
  input  logic                                                  rst_n,
  input  logic                                                  start,
  input  logic [2*SAMPLE_BITS+$clog2(SAMPLES)-1:0]              operand,
  output logic                                                  done,
  output logic [SAMPLE_BITS-1:0]                                root
);

  localparam int SQ_W  = 2 * SAMPLE_BITS;
  localparam int LOG_N = $clog2(SAMPLES);
  localparam int SUM_W = SQ_W + LOG_N;
  localparam int R_W   = SAMPLE_BITS;
  localparam int SR_W  = R_W + LOG_N;
  localparam int RR_W  = R_W + LOG_N + 3;
  localparam int CNT_W = $clog2(R_W + 1);

  typedef enum logic {R_IDLE, R_SQRT} phase_t;

  phase_t             phase_r;
  logic [CNT_W-1:0]   cnt_r;
  logic [SQ_W-1:0]    x_r;
  logic [RR_W-1:0]    sr_r;
  logic [SR_W-1:0]    sm_r;
  logic [R_W-1:0]     root_r;
  logic               done_r;

  logic [RR_W-1:0]    rem_sh;
  logic [RR_W-1:0]    trial;
  logic               sq_ge;

  // root r is the largest value with SAMPLES * r * r <= sum
  // sm_r tracks SAMPLES * r so no divide is needed
  always_comb begin
    rem_sh = {sr_r[RR_W-3:0], x_r[SQ_W-1 -: 2]};
    trial  = RR_W'({sm_r, 2'b00}) + RR_W'(SAMPLES);
    sq_ge  = (rem_sh >= trial);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= R_IDLE;
      cnt_r   <= '0;
      done_r  <= 1'b0;
    end else begin
      case (phase_r)
        R_IDLE: begin
          if (start) begin
            done_r  <= 1'b0;
            x_r     <= operand[SQ_W-1:0];
            sr_r    <= RR_W'(operand[SUM_W-1:SQ_W]);
            sm_r    <= '0;
            root_r  <= '0;
            cnt_r   <= CNT_W'(R_W);
            phase_r <= R_SQRT;
          end
        end
        R_SQRT: begin
          x_r    <= x_r << 2;
          sr_r   <= sq_ge ? (rem_sh - trial) : rem_sh;
          sm_r   <= sq_ge ? (SR_W'({sm_r, 1'b0}) + SR_W'(SAMPLES)) : SR_W'({sm_r, 1'b0});
          root_r <= {root_r[R_W-2:0], sq_ge};
          cnt_r  <= cnt_r - 1'b1;
          if (cnt_r == CNT_W'(1)) begin
            done_r  <= 1'b1;
            phase_r <= R_IDLE;
          end
        end
        default: begin
          phase_r <= R_IDLE;
        end
      endcase
    end
  end

  assign done = done_r;
  assign root = root_r;

endmodule

### rtl/dtvr_dp.sv
// ---------------------------------------------------------------------------
// dtvr_dp
// datapath: input capture, squaring, window sums, rms, relay state, result
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module dtvr_dp #(
  parameter int SAMPLES     = 16,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  dtvr_pkg::cmd_t                        cmd,
  output dtvr_pkg::st_t                         st,
  input  logic                                  in_op,
  input  logic signed [dtvr_pkg::FIELD_W-1:0]   in_sample_a,
  input  logic signed [dtvr_pkg::FIELD_W-1:0]   in_sample_b,
  input  logic signed [dtvr_pkg::FIELD_W-1:0]   in_sample_c,
  input  logic                                  cfg_we,
  input  logic [dtvr_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [dtvr_pkg::REG_W-1:0]            cfg_data,
  output logic                                  out_rms_valid,
  output logic [dtvr_pkg::FIELD_W-1:0]          out_rms_a,
  output logic [dtvr_pkg::FIELD_W-1:0]          out_rms_b,
  output logic [dtvr_pkg::FIELD_W-1:0]          out_rms_c,
  output logic                                  out_alarm_active,
  output logic                                  out_alarm_done,
  output logic                                  out_raise_active,
  output logic                                  out_lower_active,
  output logic [dtvr_pkg::FIELD_W-1:0]          out_raise_total,
  output logic [dtvr_pkg::FIELD_W-1:0]          out_lower_total
);

  localparam int SB    = SAMPLE_BITS;
  localparam int SQ_W  = 2 * SB;
  localparam int SUM_W = SQ_W + $clog2(SAMPLES);
  localparam int R_W   = SB;
  localparam int POS_W = $clog2(SAMPLES);
  localparam int CMP_W = (R_W > dtvr_pkg::REG_W) ? R_W : dtvr_pkg::REG_W;
  localparam int W     = dtvr_pkg::FIELD_W;

  // configuration
  logic [dtvr_pkg::REG_W-1:0] upper_r;
  logic [dtvr_pkg::REG_W-1:0] lower_r;
  logic [dtvr_pkg::REG_W-1:0] delay_cfg_r;

  // item and window
  logic                op_r;
  logic [W-1:0]        samp_r [dtvr_pkg::CH_NUM];
  logic [SQ_W-1:0]     sq_r;
  logic [SUM_W-1:0]    sum_r  [dtvr_pkg::CH_NUM];
  logic [POS_W-1:0]    pos_r;
  logic [R_W-1:0]      rms_r  [dtvr_pkg::CH_NUM];
  logic                rms_valid_r;

  // relay state
  logic                alarm_started_r;
  logic                alarm_elapsed_r;
  logic [dtvr_pkg::REG_W-1:0] delay_r;
  logic                alarm_f_r;
  logic                raise_f_r;
  logic                lower_f_r;
  logic [W-1:0]        raise_cnt_r;
  logic [W-1:0]        lower_cnt_r;

  // result register
  logic                o_rms_valid_r;
  logic [W-1:0]        o_rms_r [dtvr_pkg::CH_NUM];
  logic                o_alarm_r;
  logic                o_done_r;
  logic                o_raise_r;
  logic                o_lower_r;
  logic [W-1:0]        o_raise_cnt_r;
  logic [W-1:0]        o_lower_cnt_r;

  logic [SB-1:0]       raw;
  logic [SB-1:0]       mag;
  logic                root_done;
  logic [R_W-1:0]      root;
  logic                too_high;
  logic                too_low;

  dtvr_root #(
    .SAMPLES     (SAMPLES),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_root (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (cmd.root_start),
    .operand (sum_r[cmd.ch]),
    .done    (root_done),
    .root    (root)
  );

  always_comb begin
    raw = SB'(samp_r[cmd.ch]);
    mag = raw[SB-1] ? (~raw + 1'b1) : raw;
  end

  always_comb begin
    too_high = 1'b0;
    too_low  = 1'b0;
    for (int i = 0; i < dtvr_pkg::CH_NUM; i++) begin
      if (CMP_W'(rms_r[i]) > CMP_W'(upper_r)) too_high = 1'b1;
      if (CMP_W'(rms_r[i]) < CMP_W'(lower_r)) too_low  = 1'b1;
    end
  end

  assign st.op_tick   = op_r;
  assign st.win_last  = (pos_r == POS_W'(SAMPLES - 1));
  assign st.root_done = root_done;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upper_r     <= dtvr_pkg::UPPER_RST;
      lower_r     <= dtvr_pkg::LOWER_RST;
      delay_cfg_r <= dtvr_pkg::DELAY_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        dtvr_pkg::REG_UPPER: upper_r     <= cfg_data;
        dtvr_pkg::REG_LOWER: lower_r     <= cfg_data;
        dtvr_pkg::REG_DELAY: delay_cfg_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // item capture and squaring
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r      <= in_op;
      samp_r[0] <= $unsigned(in_sample_a);
      samp_r[1] <= $unsigned(in_sample_b);
      samp_r[2] <= $unsigned(in_sample_c);
    end
    if (cmd.square) begin
      sq_r <= SQ_W'(mag) * SQ_W'(mag);
    end
  end

  // window sums and rms
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < dtvr_pkg::CH_NUM; i++) begin
        sum_r[i] <= '0;
      end
      pos_r       <= '0;
      rms_valid_r <= 1'b0;
    end else begin
      if (cmd.accum) begin
        sum_r[cmd.ch] <= sum_r[cmd.ch] + SUM_W'(sq_r);
      end else if (cmd.rms_store) begin
        sum_r[cmd.ch] <= '0;
      end
      if (cmd.pos_step) begin
        pos_r <= st.win_last ? '0 : pos_r + 1'b1;
      end
      if (cmd.load) begin
        rms_valid_r <= 1'b0;
      end else if (cmd.pos_step && st.win_last) begin
        rms_valid_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      for (int i = 0; i < dtvr_pkg::CH_NUM; i++) begin
        rms_r[i] <= '0;
      end
    end else if (cmd.rms_store) begin
      rms_r[cmd.ch] <= root;
    end
  end

  // relay state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alarm_started_r <= 1'b0;
      alarm_elapsed_r <= 1'b0;
      delay_r         <= '0;
      alarm_f_r       <= 1'b0;
      raise_f_r       <= 1'b0;
      lower_f_r       <= 1'b0;
      raise_cnt_r     <= '0;
      lower_cnt_r     <= '0;
    end else if (cmd.tick) begin
      if (alarm_started_r && !alarm_elapsed_r) begin
        if (delay_r <= dtvr_pkg::REG_W'(1)) begin
          delay_r         <= '0;
          alarm_elapsed_r <= 1'b1;
        end else begin
          delay_r <= delay_r - 1'b1;
        end
      end
    end else if (cmd.eval) begin
      if (too_high || too_low) begin
        if (alarm_elapsed_r) begin
          if (too_high) begin
            lower_f_r   <= 1'b1;
            lower_cnt_r <= lower_cnt_r + 1'b1;
          end else begin
            raise_f_r   <= 1'b1;
            raise_cnt_r <= raise_cnt_r + 1'b1;
          end
        end else if (!alarm_started_r) begin
          alarm_f_r       <= 1'b1;
          alarm_started_r <= 1'b1;
          delay_r         <= delay_cfg_r;
        end
      end else begin
        alarm_f_r       <= 1'b0;
        raise_f_r       <= 1'b0;
        lower_f_r       <= 1'b0;
        alarm_started_r <= 1'b0;
        alarm_elapsed_r <= 1'b0;
        delay_r         <= '0;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.publish) begin
      o_rms_valid_r <= rms_valid_r;
      for (int i = 0; i < dtvr_pkg::CH_NUM; i++) begin
        o_rms_r[i] <= W'(rms_r[i]);
      end
      o_alarm_r     <= alarm_f_r;
      o_done_r      <= alarm_elapsed_r;
      o_raise_r     <= raise_f_r;
      o_lower_r     <= lower_f_r;
      o_raise_cnt_r <= raise_cnt_r;
      o_lower_cnt_r <= lower_cnt_r;
    end
  end

  assign out_rms_valid    = o_rms_valid_r;
  assign out_rms_a        = o_rms_r[0];
  assign out_rms_b        = o_rms_r[1];
  assign out_rms_c        = o_rms_r[2];
  assign out_alarm_active = o_alarm_r;
  assign out_alarm_done   = o_done_r;
  assign out_raise_active = o_raise_r;
  assign out_lower_active = o_lower_r;
  assign out_raise_total  = o_raise_cnt_r;
  assign out_lower_total  = o_lower_cnt_r;

  `AST_ON_CLK(a_elapsed_needs_start, clk, rst_n, alarm_elapsed_r |-> alarm_started_r, "alarm elapsed without start")
  `AST_ON_CLK(a_drive_needs_elapsed, clk, rst_n, (raise_f_r || lower_f_r) |-> alarm_elapsed_r, "drive without elapsed delay")
  `AST_ON_CLK(a_close_sets_valid, clk, rst_n, (cmd.pos_step && st.win_last) |=> rms_valid_r, "window close lost")

endmodule

### rtl/dtvr_ctrl.sv
// ---------------------------------------------------------------------------
// dtvr_ctrl
// controller: sequences squaring, window close, evaluation and result handoff
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module dtvr_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  output logic           out_valid,
  input  logic           out_ready,
  output dtvr_pkg::cmd_t cmd,
  input  dtvr_pkg::st_t  st
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_SQ,
    S_ACC,
    S_STEP,
    S_ROOT_GO,
    S_ROOT_WAIT,
    S_STORE,
    S_EVAL,
    S_TICK,
    S_PUB
  } state_t;

  state_t                    state_r, state_nxt;
  logic [dtvr_pkg::CH_W-1:0] ch_r, ch_nxt;
  logic                      in_ready_r;
  logic                      out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt = state_r;
    ch_nxt    = ch_r;
    cmd       = '0;
    cmd.ch    = ch_r;
    case (state_r)
      S_IDLE: begin
        cmd.load = in_valid && in_ready_r;
        if (cmd.load) state_nxt = S_DISPATCH;
      end
      S_DISPATCH: begin
        ch_nxt    = '0;
        state_nxt = st.op_tick ? S_TICK : S_SQ;
      end
      S_SQ: begin
        cmd.square = 1'b1;
        state_nxt  = S_ACC;
      end
      S_ACC: begin
        cmd.accum = 1'b1;
        if (ch_r == dtvr_pkg::CH_LAST) begin
          ch_nxt    = '0;
          state_nxt = S_STEP;
        end else begin
          ch_nxt    = ch_r + 1'b1;
          state_nxt = S_SQ;
        end
      end
      S_STEP: begin
        cmd.pos_step = 1'b1;
        state_nxt    = st.win_last ? S_ROOT_GO : S_PUB;
      end
      S_ROOT_GO: begin
        cmd.root_start = 1'b1;
        state_nxt      = S_ROOT_WAIT;
      end
      S_ROOT_WAIT: begin
        if (st.root_done) state_nxt = S_STORE;
      end
      S_STORE: begin
        cmd.rms_store = 1'b1;
        if (ch_r == dtvr_pkg::CH_LAST) begin
          ch_nxt    = '0;
          state_nxt = S_EVAL;
        end else begin
          ch_nxt    = ch_r + 1'b1;
          state_nxt = S_ROOT_GO;
        end
      end
      S_EVAL: begin
        cmd.eval  = 1'b1;
        state_nxt = S_PUB;
      end
      S_TICK: begin
        cmd.tick  = 1'b1;
        state_nxt = S_PUB;
      end
      S_PUB: begin
        cmd.publish = !out_valid_r || out_ready;
        if (cmd.publish) state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (cmd.publish) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      ch_r        <= '0;
      in_ready_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ch_r        <= ch_nxt;
      in_ready_r  <= (state_nxt == S_IDLE);
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = in_ready_r;
  assign out_valid = out_valid_r;

  `AST_ON_CLK(a_publish_shows, clk, rst_n, cmd.publish |=> out_valid_r, "published item not shown")
  `AST_ON_CLK(a_accept_closes, clk, rst_n, (in_valid && in_ready_r) |=> !in_ready_r, "second item taken while busy")
  `AST_ON_CLK(a_root_restart, clk, rst_n, cmd.root_start |=> !st.root_done, "stale root result")
  `AST_NO_RST(a_reset_clears_out, clk, !rst_n |=> !out_valid_r, "result valid out of reset")

endmodule

### rtl/definite_time_voltage_regulator_top.sv
// sample item: squares and sums each channel; tick item: counts down the relay delay
// window-closing item also roots each channel in the shared root unit, then evaluates
// one item at a time; the next is taken in the cycle after the result is registered
// synchronous active-low reset clears sums, window position, relay state and counters
// ---------------------------------------------------------------------------
// definite_time_voltage_regulator_top
// three-channel rms voltage relay with definite time raise/lower drive
// ---------------------------------------------------------------------------
module definite_time_voltage_regulator_top #(
  parameter int SAMPLES     = 16,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                in_op,
  input  logic signed [dtvr_pkg::FIELD_W-1:0] in_sample_a,
  input  logic signed [dtvr_pkg::FIELD_W-1:0] in_sample_b,
  input  logic signed [dtvr_pkg::FIELD_W-1:0] in_sample_c,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic                                out_rms_valid,
  output logic [dtvr_pkg::FIELD_W-1:0]        out_rms_a,
  output logic [dtvr_pkg::FIELD_W-1:0]        out_rms_b,
  output logic [dtvr_pkg::FIELD_W-1:0]        out_rms_c,
  output logic                                out_alarm_active,
  output logic                                out_alarm_done,
  output logic                                out_raise_active,
  output logic                                out_lower_active,
  output logic [dtvr_pkg::FIELD_W-1:0]        out_raise_total,
  output logic [dtvr_pkg::FIELD_W-1:0]        out_lower_total,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [dtvr_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [dtvr_pkg::REG_W-1:0]          cfg_data
);

  dtvr_pkg::cmd_t cmd;
  dtvr_pkg::st_t  st;

  assign cfg_ready = 1'b1;

  dtvr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .st        (st)
  );

  dtvr_dp #(
    .SAMPLES     (SAMPLES),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .st               (st),
    .in_op            (in_op),
    .in_sample_a      (in_sample_a),
    .in_sample_b      (in_sample_b),
    .in_sample_c      (in_sample_c),
    .cfg_we           (cfg_valid && cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .out_rms_valid    (out_rms_valid),
    .out_rms_a        (out_rms_a),
    .out_rms_b        (out_rms_b),
    .out_rms_c        (out_rms_c),
    .out_alarm_active (out_alarm_active),
    .out_alarm_done   (out_alarm_done),
    .out_raise_active (out_raise_active),
    .out_lower_active (out_lower_active),
    .out_raise_total  (out_raise_total),
    .out_lower_total  (out_lower_total)
  );

endmodule
